// ===== src/fat32_chain_to_sector_runs_macros.svh =====
// Assertion macros used by the step logic of the cluster chain walker RTL.
`ifndef FAT32_CHAIN_TO_SECTOR_RUNS_MACROS_SVH
`define FAT32_CHAIN_TO_SECTOR_RUNS_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define FCSR_ASSERT_IMP(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset
`define FCSR_ASSERT_NXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCSR_ASSERT_IMP(label, clock, resetn, ante, cons, msg)
`define FCSR_ASSERT_NXT(label, clock, resetn, ante, cons, msg)
`endif
`endif

// ===== src/fcsr_pkg.sv =====
// Shared widths, codes and types of the FAT32 cluster chain walker.
package fcsr_pkg;

    // Field widths
    localparam int SEC_W    = 32;
    localparam int CLUS_W   = 28;
    localparam int LEN_W    = 24;
    localparam int STEP_W   = 25;
    localparam int BYTES_W  = 32;
    localparam int LOG2_W   = 3;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 32;

    // Sector size, a power of two
    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    // FAT32 entry codes (after masking to 28 bits)
    localparam logic [CLUS_W-1:0] ENTRY_FREE    = 28'h0000000;
    localparam logic [CLUS_W-1:0] ENTRY_BAD     = 28'hFFFFFF7;
    localparam logic [CLUS_W-1:0] ENTRY_EOC_MIN = 28'hFFFFFF8;
    localparam logic [CLUS_W-1:0] FIRST_DATA    = 28'd2;
    localparam logic [STEP_W-1:0] STEP_MAX      = {STEP_W{1'b1}};

    // Walk status codes
    localparam logic [STATUS_W-1:0] ST_CONT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_LOG2  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CLUSTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_BYTES    = 3'd4;

    // Register reset values
    localparam logic [CLUS_W-1:0] COUNT_RESET = 28'd65525;
    localparam logic [CLUS_W-1:0] FIRST_RESET = 28'd2;

    typedef struct packed {
        logic [SEC_W-1:0]   data_start_sector;
        logic [LOG2_W-1:0]  cluster_size_log2;
        logic [CLUS_W-1:0]  cluster_count;
        logic [CLUS_W-1:0]  first_cluster;
        logic [BYTES_W-1:0] file_bytes;
    } cfg_t;

    typedef struct packed {
        logic                run_valid;
        logic [SEC_W-1:0]    run_sector;
        logic [LEN_W-1:0]    run_length;
        logic [CLUS_W-1:0]   fetch_cluster;
        logic [STATUS_W-1:0] walk_status;
    } res_t;

endpackage

// ===== src/fcsr_if.sv =====
// Valid/ready channel interfaces for FAT entries in and sector runs out.
interface fcsr_in_if;
    logic                              valid;
    logic                              ready;
    logic [fcsr_pkg::ENTRY_W-1:0]      fat_entry;
    logic                              start_req;

    modport source (output valid, fat_entry, start_req, input ready);
    modport sink   (input valid, fat_entry, start_req, output ready);
endinterface

interface fcsr_out_if;
    logic                              valid;
    logic                              ready;
    logic                              run_valid;
    logic [fcsr_pkg::SEC_W-1:0]        run_sector;
    logic [fcsr_pkg::LEN_W-1:0]        run_length;
    logic [fcsr_pkg::CLUS_W-1:0]       fetch_cluster;
    logic [fcsr_pkg::STATUS_W-1:0]     walk_status;

    modport source (output valid, run_valid, run_sector, run_length, fetch_cluster,
                    walk_status, input ready);
    modport sink   (input valid, run_valid, run_sector, run_length, fetch_cluster,
                    walk_status, output ready);
endinterface

// ===== src/fcsr_cfg.sv =====
// Configuration register file of the cluster chain walker.
module fcsr_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fcsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output fcsr_pkg::cfg_t                  cfg
);

    fcsr_pkg::cfg_t cfg_reg;
    fcsr_pkg::cfg_t cfg_next;

    // Write decode; indexes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                fcsr_pkg::REG_DATA_START:
                    cfg_next.data_start_sector = cfg_wdata[fcsr_pkg::SEC_W-1:0];
                fcsr_pkg::REG_CLUSTER_LOG2:
                    cfg_next.cluster_size_log2 = cfg_wdata[fcsr_pkg::LOG2_W-1:0];
                fcsr_pkg::REG_CLUSTER_COUNT:
                    cfg_next.cluster_count = cfg_wdata[fcsr_pkg::CLUS_W-1:0];
                fcsr_pkg::REG_FIRST_CLUSTER:
                    cfg_next.first_cluster = cfg_wdata[fcsr_pkg::CLUS_W-1:0];
                fcsr_pkg::REG_FILE_BYTES:
                    cfg_next.file_bytes = cfg_wdata[fcsr_pkg::BYTES_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_start_sector <= '0;
            cfg_reg.cluster_size_log2 <= '0;
            cfg_reg.cluster_count     <= fcsr_pkg::COUNT_RESET;
            cfg_reg.first_cluster     <= fcsr_pkg::FIRST_RESET;
            cfg_reg.file_bytes        <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/fcsr_step.sv =====
// Walk state and combinational step logic: link check, run merge and clipping.
`include "fat32_chain_to_sector_runs_macros.svh"

module fcsr_step #(
    parameter int SECTOR_BYTES = fcsr_pkg::SECTOR_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcsr_pkg::cfg_t                cfg,
    input  logic                          step_en,
    input  logic [fcsr_pkg::ENTRY_W-1:0]  fat_entry,
    input  logic                          start_req,
    output fcsr_pkg::res_t                res
);

    localparam int CLUS_W       = fcsr_pkg::CLUS_W;
    localparam int LEN_W        = fcsr_pkg::LEN_W;
    localparam int STEP_W       = fcsr_pkg::STEP_W;
    localparam int SEC_W        = fcsr_pkg::SEC_W;
    localparam int BND_W        = fcsr_pkg::BYTES_W + 1;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    // Walk state
    logic [CLUS_W-1:0] cur_reg, cur_next;
    logic [CLUS_W-1:0] begin_reg, begin_next;
    logic [LEN_W-1:0]  rsf_reg, rsf_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              walk_reg, walk_next;

    // Step datapath
    logic [CLUS_W-1:0] entry;
    logic [LEN_W-1:0]  clus_secs;
    logic [BND_W-1:0]  byte_sum;
    logic [BND_W-1:0]  sec_round;
    logic [LEN_W-1:0]  sectors_init;
    logic [BND_W-1:0]  bound;
    logic              walk_eff;
    logic [CLUS_W-1:0] e_cur;
    logic [CLUS_W-1:0] e_begin;
    logic [LEN_W-1:0]  e_rsf;
    logic [LEN_W-1:0]  e_rem;
    logic [STEP_W-1:0] e_step;
    logic [LEN_W-1:0]  rsf_sum;
    logic [CLUS_W-1:0] next_clus;
    logic              link_bad;
    logic              emit;
    logic [LEN_W-1:0]  run_len;
    logic [LEN_W-1:0]  rem_after;
    logic [SEC_W-1:0]  begin_off;

    // Cluster lies in the data area [2, count + 2)
    function automatic logic in_range(input logic [CLUS_W-1:0] c,
                                      input logic [CLUS_W-1:0] count);
        logic [CLUS_W:0] limit;
        begin
            limit = {1'b0, count} + {1'b0, fcsr_pkg::FIRST_DATA};
            in_range = (c >= fcsr_pkg::FIRST_DATA) && ({1'b0, c} < limit);
        end
    endfunction

    // Per-volume and per-file derived values
    always_comb
    begin
        entry        = fat_entry[CLUS_W-1:0];
        clus_secs    = LEN_W'(1) << cfg.cluster_size_log2;
        byte_sum     = {1'b0, cfg.file_bytes} + BND_W'(SECTOR_BYTES - 1);
        sec_round    = byte_sum >> SECTOR_SHIFT;
        sectors_init = sec_round[LEN_W-1:0];
        bound        = ({1'b0, cfg.file_bytes} >>
                        (SECTOR_SHIFT + int'(cfg.cluster_size_log2)))
                       + BND_W'(2);
    end

    // A start request reloads the walk before this entry is used
    always_comb
    begin
        walk_eff = start_req ? (cfg.file_bytes != '0) : walk_reg;
        e_cur    = start_req ? cfg.first_cluster : cur_reg;
        e_begin  = start_req ? cfg.first_cluster : begin_reg;
        e_rsf    = start_req ? '0 : rsf_reg;
        e_rem    = start_req ? sectors_init : rem_reg;
        e_step   = start_req ? '0 : step_reg;
    end

    // Link decode, run merge and clipping
    always_comb
    begin
        rsf_sum   = e_rsf + clus_secs;
        link_bad  = 1'b0;
        next_clus = entry;
        if (entry >= fcsr_pkg::ENTRY_EOC_MIN)
        begin
            next_clus = '0;
        end
        else if ((entry == fcsr_pkg::ENTRY_FREE) || (entry == fcsr_pkg::ENTRY_BAD) ||
                 !in_range(entry, cfg.cluster_count))
        begin
            link_bad = 1'b1;
        end
        emit      = ({1'b0, next_clus} != ({1'b0, e_cur} + (CLUS_W+1)'(1))) ||
                    (rsf_sum >= e_rem);
        run_len   = (rsf_sum > e_rem) ? e_rem : rsf_sum;
        rem_after = emit ? (e_rem - run_len) : e_rem;
        begin_off = SEC_W'(e_begin) - SEC_W'(fcsr_pkg::FIRST_DATA);
    end

    // Result and next state
    always_comb
    begin
        cur_next   = cur_reg;
        begin_next = begin_reg;
        rsf_next   = rsf_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        walk_next  = 1'b0;

        res.run_valid     = 1'b0;
        res.run_sector    = '0;
        res.run_length    = '0;
        res.fetch_cluster = '0;
        res.walk_status   = fcsr_pkg::ST_DONE;

        if (walk_eff)
        begin
            cur_next   = e_cur;
            begin_next = e_begin;
            rsf_next   = e_rsf;
            rem_next   = e_rem;
            step_next  = e_step;
            if (BND_W'(e_step) > bound)
            begin
                // Step bound exceeded: chain loops
                res.walk_status = fcsr_pkg::ST_CORRUPT;
            end
            else
            begin
                step_next = (e_step == fcsr_pkg::STEP_MAX) ? e_step : e_step + STEP_W'(1);
                rsf_next  = rsf_sum;
                if (!in_range(e_cur, cfg.cluster_count) || link_bad)
                begin
                    res.walk_status = fcsr_pkg::ST_CORRUPT;
                end
                else
                begin
                    if (emit)
                    begin
                        res.run_valid  = 1'b1;
                        res.run_length = run_len;
                        res.run_sector = cfg.data_start_sector +
                                         (begin_off << cfg.cluster_size_log2);
                        rsf_next       = '0;
                        begin_next     = next_clus;
                    end
                    rem_next = rem_after;
                    if ((next_clus == '0) || (rem_after == '0))
                    begin
                        res.walk_status = fcsr_pkg::ST_DONE;
                    end
                    else
                    begin
                        cur_next          = next_clus;
                        walk_next         = 1'b1;
                        res.fetch_cluster = next_clus;
                        res.walk_status   = fcsr_pkg::ST_CONT;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            begin_reg <= '0;
            rsf_reg   <= '0;
            rem_reg   <= '0;
            step_reg  <= '0;
            walk_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            cur_reg   <= cur_next;
            begin_reg <= begin_next;
            rsf_reg   <= rsf_next;
            rem_reg   <= rem_next;
            step_reg  <= step_next;
            walk_reg  <= walk_next;
        end
    end

    // Checks
    `FCSR_ASSERT_IMP(a_corrupt_no_run, clk, rst_n, (res.walk_status == fcsr_pkg::ST_CORRUPT), (!res.run_valid && (res.fetch_cluster == '0)), "corrupt step emits a run or a fetch")
    `FCSR_ASSERT_IMP(a_no_run_zero, clk, rst_n, !res.run_valid, ((res.run_sector == '0) && (res.run_length == '0)), "idle run fields not zero")
    `FCSR_ASSERT_IMP(a_cont_fetch, clk, rst_n, (res.walk_status == fcsr_pkg::ST_CONT), ((res.fetch_cluster != '0) && walk_next), "continuing walk without a fetch")
    `FCSR_ASSERT_NXT(a_end_idle, clk, rst_n, (step_en && (res.walk_status != fcsr_pkg::ST_CONT)), !walk_reg, "walk still active after it ended")

endmodule

// ===== src/fat32_chain_to_sector_runs.sv =====
// Top level of the FAT32 cluster chain walker: input stage, step logic, result stage.
//
// Usage: write the volume and file registers through the cfg port while the block
// is idle, then feed FAT entries on fat_in. The first item carries start_req = 1
// and the entry of first_cluster; each later item carries the entry of the cluster
// named by the previous result's fetch_cluster. Every item gives exactly one result
// on run_out: an optional sector run (run_valid, run_sector, run_length), the next
// cluster to fetch and walk_status (0 continuing, 1 finished, 2 chain corrupt).
// An accepted item waits in the input register while the step logic works on it, and
// its result is then captured in the result register, which drives run_out.
// Throughput is one item per cycle while run_out does not stall; the walk state is
// updated once per step, so back-to-back entries follow each other with no gap.
// Reset clears the walk (idle) and loads the register defaults; no items are held.
// When run_out stalls, the result register holds and the input register fills,
// then fat_in.ready drops until the receiver takes the waiting result.
module fat32_chain_to_sector_runs #(
    parameter int SECTOR_BYTES = fcsr_pkg::SECTOR_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fcsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    fcsr_in_if.sink                         fat_in,
    fcsr_out_if.source                      run_out
);

    fcsr_pkg::cfg_t cfg;
    fcsr_pkg::res_t step_res;

    // Input stage
    logic                          in_valid_reg;
    logic [fcsr_pkg::ENTRY_W-1:0]  entry_reg;
    logic                          start_reg;

    // Result stage
    logic                          out_valid_reg;
    fcsr_pkg::res_t                res_reg;

    logic advance;
    logic in_take;

    assign advance      = !out_valid_reg || run_out.ready;
    assign fat_in.ready = !in_valid_reg || advance;
    assign in_take      = fat_in.valid && fat_in.ready;

    fcsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fcsr_step #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step_en   (in_valid_reg && advance),
        .fat_entry (entry_reg),
        .start_req (start_reg),
        .res       (step_res)
    );

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            entry_reg <= fat_in.fat_entry;
            start_reg <= fat_in.start_req;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            res_reg <= step_res;
        end
    end

    assign run_out.valid         = out_valid_reg;
    assign run_out.run_valid     = res_reg.run_valid;
    assign run_out.run_sector    = res_reg.run_sector;
    assign run_out.run_length    = res_reg.run_length;
    assign run_out.fetch_cluster = res_reg.fetch_cluster;
    assign run_out.walk_status   = res_reg.walk_status;

endmodule
